>>> sv/dcf_pkg.sv
// ----------------------------------------------------------------------------
// dcf_pkg
// Shared types and constants for the diagonal corner finder: frame limits,
// coordinate widths, configuration register indexes and corner slots.
// ----------------------------------------------------------------------------
`default_nettype none

package dcf_pkg;

    localparam int MAX_COLS   = 4096;
    localparam int MAX_ROWS   = 4096;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 12;
    localparam int SIZE_W     = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [PIX_W-1:0]  THRESHOLD_RESET = 8'd128;
    localparam logic [SIZE_W-1:0] COLS_MAX_VAL    = SIZE_W'(MAX_COLS);
    localparam logic [SIZE_W-1:0] ROWS_MAX_VAL    = SIZE_W'(MAX_ROWS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WHITE_THRESHOLD = 2'd0,
        REG_FRAME_COLS      = 2'd1,
        REG_FRAME_ROWS      = 2'd2
    } cfg_reg_t;

    localparam int CORNER_NW   = 0;
    localparam int CORNER_NE   = 1;
    localparam int CORNER_SW   = 2;
    localparam int CORNER_SE   = 3;
    localparam int NUM_CORNERS = 4;

    typedef logic [COORD_W-1:0] coord_t;

    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [SIZE_W-1:0] v,
        input logic [SIZE_W-1:0] max_val
    );
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > max_val)
            r = max_val;
        else
            r = v;
        return r;
    endfunction

endpackage : dcf_pkg

`default_nettype wire

>>> sv/diagonal_corner_finder_core.sv
// ----------------------------------------------------------------------------
// diagonal_corner_finder_core
// Raster-order corner search over a thresholded grayscale frame; one result
// per frame with the four diagonal-extreme dark pixels and a found flag.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock cycle, top-left first, while in_ready is
// high. A pixel enters an input register; a single pass of compare-and-update
// logic against the four stored corners moves it into the frame state unless
// a result waits untaken. The frame result is loaded into the output register
// as its last pixel leaves the input register and stays until taken; pixels
// keep flowing while no result waits, and input ready drops only while the
// result register is full and not being taken and the input register holds a
// pixel that cannot move. The user must write frame size and threshold
// through the configuration port only while no pixel is in flight; the
// block does not enforce this. Sizes of zero act as one, above 4096 as 4096.
`default_nettype none

module diagonal_corner_finder_core
    import dcf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [PIX_W-1:0]      gray_pixel,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [COORD_W-1:0]         nw_x,
    output logic [COORD_W-1:0]         nw_y,
    output logic [COORD_W-1:0]         ne_x,
    output logic [COORD_W-1:0]         ne_y,
    output logic [COORD_W-1:0]         sw_x,
    output logic [COORD_W-1:0]         sw_y,
    output logic [COORD_W-1:0]         se_x,
    output logic [COORD_W-1:0]         se_y,
    output logic                       found
);

    logic [PIX_W-1:0]   threshold_reg;
    logic [SIZE_W-1:0]  cols_cfg_reg;
    logic [SIZE_W-1:0]  rows_cfg_reg;

    logic [PIX_W-1:0]   pix_reg;
    logic               pix_valid_reg;

    coord_t             col_count_reg, col_count_next;
    coord_t             row_count_reg, row_count_next;
    coord_t             best_col_reg [NUM_CORNERS];
    coord_t             best_col_next [NUM_CORNERS];
    coord_t             best_row_reg [NUM_CORNERS];
    coord_t             best_row_next [NUM_CORNERS];
    logic               any_found_reg, any_found_next;

    logic               out_valid_reg;
    coord_t             res_col_reg [NUM_CORNERS];
    coord_t             res_row_reg [NUM_CORNERS];
    logic               found_reg;

    logic [SIZE_W-1:0]  cols_eff;
    logic [SIZE_W-1:0]  rows_eff;
    logic               advance;
    logic               dark;
    logic               last_col;
    logic               last_row;
    logic               frame_end;
    logic [SIZE_W-1:0]  sum_cur;
    logic [SIZE_W-1:0]  sum_nw;
    logic [SIZE_W-1:0]  sum_se;
    logic signed [SIZE_W:0] diff_cur;
    logic signed [SIZE_W:0] diff_ne;
    logic signed [SIZE_W:0] diff_sw;
    logic [NUM_CORNERS-1:0] take;

    assign cols_eff  = clamp_size(cols_cfg_reg, COLS_MAX_VAL);
    assign rows_eff  = clamp_size(rows_cfg_reg, ROWS_MAX_VAL);

    assign advance   = pix_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !pix_valid_reg || advance;

    assign dark      = (pix_reg <= threshold_reg);
    assign last_col  = ({1'b0, col_count_reg} + SIZE_W'(1)) >= cols_eff;
    assign last_row  = ({1'b0, row_count_reg} + SIZE_W'(1)) >= rows_eff;
    assign frame_end = last_col && last_row;

    assign sum_cur  = {1'b0, col_count_reg} + {1'b0, row_count_reg};
    assign sum_nw   = {1'b0, best_col_reg[CORNER_NW]} + {1'b0, best_row_reg[CORNER_NW]};
    assign sum_se   = {1'b0, best_col_reg[CORNER_SE]} + {1'b0, best_row_reg[CORNER_SE]};
    assign diff_cur = $signed({2'b00, col_count_reg}) - $signed({2'b00, row_count_reg});
    assign diff_ne  = $signed({2'b00, best_col_reg[CORNER_NE]})
                    - $signed({2'b00, best_row_reg[CORNER_NE]});
    assign diff_sw  = $signed({2'b00, best_row_reg[CORNER_SW]})
                    - $signed({2'b00, best_col_reg[CORNER_SW]});

    always_comb
    begin
        take[CORNER_NW] = sum_cur <= sum_nw;
        take[CORNER_NE] = diff_cur > diff_ne;
        take[CORNER_SW] = -diff_cur > diff_sw;
        take[CORNER_SE] = sum_cur >= sum_se;
        if (!any_found_reg)
            take = '1;
        if (!dark)
            take = '0;
    end

    always_comb
    begin
        any_found_next = any_found_reg || dark;
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            best_col_next[k] = take[k] ? col_count_reg : best_col_reg[k];
            best_row_next[k] = take[k] ? row_count_reg : best_row_reg[k];
        end
        col_count_next = last_col ? '0 : col_count_reg + COORD_W'(1);
        row_count_next = row_count_reg;
        if (last_col)
            row_count_next = last_row ? '0 : row_count_reg + COORD_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            cols_cfg_reg  <= COLS_MAX_VAL;
            rows_cfg_reg  <= ROWS_MAX_VAL;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WHITE_THRESHOLD: threshold_reg <= cfg_data[PIX_W-1:0];
                REG_FRAME_COLS:      cols_cfg_reg  <= cfg_data;
                REG_FRAME_ROWS:      rows_cfg_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_valid_reg <= 1'b0;
        else if (in_ready)
            pix_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            pix_reg <= gray_pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            any_found_reg <= 1'b0;
            for (int k = 0; k < NUM_CORNERS; k++)
            begin
                best_col_reg[k] <= '0;
                best_row_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            // clear the frame state once its result has been captured
            any_found_reg <= frame_end ? 1'b0 : any_found_next;
            for (int k = 0; k < NUM_CORNERS; k++)
            begin
                best_col_reg[k] <= frame_end ? '0 : best_col_next[k];
                best_row_reg[k] <= frame_end ? '0 : best_row_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && frame_end)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && frame_end)
        begin
            found_reg <= any_found_next;
            for (int k = 0; k < NUM_CORNERS; k++)
            begin
                res_col_reg[k] <= best_col_next[k];
                res_row_reg[k] <= best_row_next[k];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign nw_x      = res_col_reg[CORNER_NW];
    assign nw_y      = res_row_reg[CORNER_NW];
    assign ne_x      = res_col_reg[CORNER_NE];
    assign ne_y      = res_row_reg[CORNER_NE];
    assign sw_x      = res_col_reg[CORNER_SW];
    assign sw_y      = res_row_reg[CORNER_SW];
    assign se_x      = res_col_reg[CORNER_SE];
    assign se_y      = res_row_reg[CORNER_SE];
    assign found     = found_reg;

`ifndef SYNTHESIS
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance && frame_end |=> out_valid_reg)
        else $error("frame end did not load the result register");

    a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        advance && frame_end |=> col_count_reg == '0 && row_count_reg == '0
                                 && !any_found_reg)
        else $error("frame state not cleared after frame end");

    a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        any_found_reg && !(advance && frame_end) |=> any_found_reg)
        else $error("found flag dropped inside a frame");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> nw_x == '0 && nw_y == '0 && ne_x == '0
            && ne_y == '0 && sw_x == '0 && sw_y == '0 && se_x == '0 && se_y == '0)
        else $error("empty frame reported nonzero corners");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(found_reg))
        else $error("pending result lost or changed");
`endif

endmodule : diagonal_corner_finder_core

`default_nettype wire

>>> dv/corner_checker.sv
// ----------------------------------------------------------------------------
// corner_checker
// Watches the configuration port and both request channels of the diagonal
// corner finder. It tracks threshold, frame size, raster position and the
// four diagonal-extreme dark pixels. It queues the corner set due at the end
// of each frame and compares every result the block hands out with the oldest
// queued set, field by field.
// ----------------------------------------------------------------------------
module corner_checker
    import dcf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic [PIX_W-1:0]      gray_pixel,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire coord_t                nw_x,
    input  wire coord_t                nw_y,
    input  wire coord_t                ne_x,
    input  wire coord_t                ne_y,
    input  wire coord_t                sw_x,
    input  wire coord_t                sw_y,
    input  wire coord_t                se_x,
    input  wire coord_t                se_y,
    input  wire logic                  found,
    output int                         corner_errors,
    output int                         frames_outstanding
);

    typedef struct packed {
        coord_t [NUM_CORNERS-1:0] cx;
        coord_t [NUM_CORNERS-1:0] cy;
        logic                     found;
    } corner_set_t;

    string corner_names [NUM_CORNERS] = '{"nw", "ne", "sw", "se"};

    logic [PIX_W-1:0]  thresh;
    logic [SIZE_W-1:0] cols_reg;
    logic [SIZE_W-1:0] rows_reg;
    int                next_col;
    int                next_row;
    int                dark_col [NUM_CORNERS];
    int                dark_row [NUM_CORNERS];
    bit                seen_dark;
    corner_set_t       frames_due [$];
    corner_set_t       done_set;
    corner_set_t       seen_set;
    corner_set_t       oldest;
    bit                frame_done;

    function automatic int usable_size(input logic [SIZE_W-1:0] v, input int limit);
        int r;
        r = (v == '0) ? 1 : int'(v);
        if (r > limit)
            r = limit;
        return r;
    endfunction

    task automatic clear_frame();
        next_col  = 0;
        next_row  = 0;
        seen_dark = 1'b0;
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            dark_col[k] = 0;
            dark_row[k] = 0;
        end
    endtask

    task automatic take_corner(input int k, input int x, input int y);
        dark_col[k] = x;
        dark_row[k] = y;
    endtask

    task automatic advance_frame(
        input  logic [PIX_W-1:0] pix,
        output bit               done,
        output corner_set_t      res
    );
        int x;
        int y;
        int cols;
        int rows;
        x    = next_col;
        y    = next_row;
        cols = usable_size(cols_reg, MAX_COLS);
        rows = usable_size(rows_reg, MAX_ROWS);
        done = 1'b0;
        res  = '0;
        if (pix <= thresh)
        begin
            if (!seen_dark)
            begin
                for (int k = 0; k < NUM_CORNERS; k++)
                    take_corner(k, x, y);
                seen_dark = 1'b1;
            end
            else
            begin
                // later pixel on the same diagonal has the larger row
                if (x + y <= dark_col[CORNER_NW] + dark_row[CORNER_NW])
                    take_corner(CORNER_NW, x, y);
                if (x - y > dark_col[CORNER_NE] - dark_row[CORNER_NE])
                    take_corner(CORNER_NE, x, y);
                if (y - x > dark_row[CORNER_SW] - dark_col[CORNER_SW])
                    take_corner(CORNER_SW, x, y);
                if (x + y >= dark_col[CORNER_SE] + dark_row[CORNER_SE])
                    take_corner(CORNER_SE, x, y);
            end
        end
        if (x + 1 < cols)
            next_col = x + 1;
        else
        begin
            next_col = 0;
            if (y + 1 < rows)
                next_row = y + 1;
            else
            begin
                for (int k = 0; k < NUM_CORNERS; k++)
                begin
                    res.cx[k] = coord_t'(dark_col[k]);
                    res.cy[k] = coord_t'(dark_row[k]);
                end
                res.found = seen_dark;
                done      = 1'b1;
                clear_frame();
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        corner_errors++;
        if (corner_errors <= 100)
            $display("[%0t] corner mismatch: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh   = THRESHOLD_RESET;
            cols_reg = COLS_MAX_VAL;
            rows_reg = ROWS_MAX_VAL;
            clear_frame();
            frames_due.delete();
            frames_outstanding = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_WHITE_THRESHOLD: thresh   = cfg_data[PIX_W-1:0];
                    REG_FRAME_COLS:      cols_reg = cfg_data[SIZE_W-1:0];
                    REG_FRAME_ROWS:      rows_reg = cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                advance_frame(gray_pixel, frame_done, done_set);
                if (frame_done)
                    frames_due.push_back(done_set);
            end
            if (out_valid && out_ready)
            begin
                seen_set.cx[CORNER_NW] = nw_x;
                seen_set.cy[CORNER_NW] = nw_y;
                seen_set.cx[CORNER_NE] = ne_x;
                seen_set.cy[CORNER_NE] = ne_y;
                seen_set.cx[CORNER_SW] = sw_x;
                seen_set.cy[CORNER_SW] = sw_y;
                seen_set.cx[CORNER_SE] = se_x;
                seen_set.cy[CORNER_SE] = se_y;
                seen_set.found         = found;
                if (frames_due.size() == 0)
                    report_mismatch("result with no frame pending");
                else
                begin
                    oldest = frames_due.pop_front();
                    for (int k = 0; k < NUM_CORNERS; k++)
                    begin
                        if (seen_set.cx[k] !== oldest.cx[k])
                            report_mismatch($sformatf("%s_x got %0d expected %0d",
                                corner_names[k], seen_set.cx[k], oldest.cx[k]));
                        if (seen_set.cy[k] !== oldest.cy[k])
                            report_mismatch($sformatf("%s_y got %0d expected %0d",
                                corner_names[k], seen_set.cy[k], oldest.cy[k]));
                    end
                    if (seen_set.found !== oldest.found)
                        report_mismatch($sformatf("found got %b expected %b",
                            seen_set.found, oldest.found));
                end
            end
            frames_outstanding = frames_due.size();
        end
    end

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for diagonal_corner_finder_core. It sets the threshold
// and the frame size while the block is idle. It streams directed frames: ties
// on the diagonals, all-white frames, zero-size frames, full-size and oversize
// frames cut short, and a size cut mid-frame. Then it streams random frames
// and partial frames, with random gaps on the pixel side and random stalls on
// the result side. Checking is done by corner_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import dcf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_PIXELS = 1100;
    localparam int WIDE_PIXELS   = 150;
    localparam int SETTLE_CYCLES = 8;

    // 4x3 frame, first pixel in the top byte
    localparam logic [12*PIX_W-1:0] CORNER_PROBE = {
        8'd255, 8'd10,  8'd200, 8'd129,
        8'd128, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd0,   8'd255, 8'd50
    };

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_write  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [PIX_W-1:0]      gray_pixel = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    coord_t                nw_x;
    coord_t                nw_y;
    coord_t                ne_x;
    coord_t                ne_y;
    coord_t                sw_x;
    coord_t                sw_y;
    coord_t                se_x;
    coord_t                se_y;
    logic                  found;
    int                    corner_errors;
    int                    frames_outstanding;

    int thr_now  = 128;
    int cols_now = MAX_COLS;
    int rows_now = MAX_ROWS;
    int sent_pixels;
    bit in_steady;
    bit out_steady;
    int stall_left;
    int steady_left;
    int idle_cycles;

    always #2 clk = ~clk;

    diagonal_corner_finder_core uut (.*);

    corner_checker chk (.*);

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic int frame_extent(input int v, input int limit);
        if (v == 0)
            return 1;
        return (v > limit) ? limit : v;
    endfunction

    function automatic int frame_len();
        return frame_extent(cols_now, MAX_COLS) * frame_extent(rows_now, MAX_ROWS);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input int dark_permille);
        if (thr_now == 255 || $urandom_range(0, 999) < dark_permille)
            return PIX_W'($urandom_range(0, thr_now));
        return PIX_W'($urandom_range(thr_now + 1, 255));
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        gap = in_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        gray_pixel <= pix;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        sent_pixels++;
    endtask

    task automatic send_frame(input int npix, input int dark_permille, input bit mark_ends);
        for (int i = 0; i < npix; i++)
            send_pixel((mark_ends && (i == 0 || i == npix - 1)) ?
                       pick_pixel(1000) : pick_pixel(dark_permille));
    endtask

    // hold requests until every pending result is out and the pipe is empty
    task automatic drain();
        in_valid <= 1'b0;
        while (frames_outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        if (idx == REG_WHITE_THRESHOLD)
            thr_now = value;
        else if (idx == REG_FRAME_COLS)
            cols_now = value;
        else if (idx == REG_FRAME_ROWS)
            rows_now = value;
    endtask

    task automatic set_frame(input int thr, input int cols, input int rows);
        drain();
        write_reg(REG_WHITE_THRESHOLD, thr);
        write_reg(REG_FRAME_COLS, cols);
        write_reg(REG_FRAME_ROWS, rows);
    endtask

    always @(negedge clk)
    begin
        if (steady_left == 0)
        begin
            out_steady  = ($urandom_range(0, 3) == 0);
            steady_left = $urandom_range(50, 400);
        end
        else
            steady_left--;
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!out_steady)
                stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("diagonal_corner_finder_core test failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int random_start;
        int phase_frames;
        int permille;
        int thr;
        int cols;
        int rows;
        int r;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        in_steady = 1'b1;
        set_frame(128, 4, 3);
        for (int i = 0; i < 12; i++)
            send_pixel(CORNER_PROBE[PIX_W*(11-i) +: PIX_W]);
        set_frame(128, 2, 1);
        send_pixel(8'd255);
        send_pixel(8'd129);
        set_frame(0, 0, 0);
        send_pixel(8'd0);
        send_pixel(8'd1);
        set_frame(255, 0, 1);
        write_reg(REG_SPARE, 5);
        send_pixel(8'd255);
        send_pixel(8'd0);
        // cut the line short after five pixels
        set_frame(200, 8, 2);
        send_frame(5, 500, 1'b0);
        set_frame(200, 3, 2);
        send_frame(3, 500, 1'b1);

        // run deep into a full-size or oversize frame, then cut it short
        in_steady = 1'b0;
        set_frame(100, 4096, 1);
        send_frame(WIDE_PIXELS, 2, 1'b1);
        set_frame(100, 2, 1);
        send_frame(1, 2, 1'b1);
        set_frame(100, 1, 4096);
        send_frame(WIDE_PIXELS, 2, 1'b1);
        set_frame(100, 1, 2);
        send_frame(1, 2, 1'b1);
        set_frame(100, 8191, 1);
        send_frame(WIDE_PIXELS, 2, 1'b1);
        set_frame(100, 2, 1);
        send_frame(1, 2, 1'b1);
        set_frame(100, 1, 5000);
        send_frame(WIDE_PIXELS, 2, 1'b1);
        set_frame(100, 1, 2);
        send_frame(1, 2, 1'b1);

        random_start = sent_pixels;
        while (sent_pixels - random_start < RANDOM_PIXELS)
        begin
            in_steady = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 9);
            thr = (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(0, 255);
            r = $urandom_range(0, 19);
            cols = (r == 0) ? 0 : (r == 1) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            r = $urandom_range(0, 19);
            rows = (r == 0) ? 0 : (r == 1) ? $urandom_range(9, 16) : $urandom_range(1, 8);
            set_frame(thr, cols, rows);
            phase_frames = $urandom_range(1, 4);
            repeat (phase_frames)
            begin
                case ($urandom_range(0, 4))
                    0:       permille = 0;
                    1:       permille = 1000;
                    2:       permille = 20;
                    3:       permille = 300;
                    default: permille = 700;
                endcase
                send_frame(frame_len(), permille, $urandom_range(0, 3) == 0);
            end
            // leave a frame open so the next size takes effect mid-frame
            if ($urandom_range(0, 5) == 0)
                send_frame($urandom_range(1, frame_len()), 300, 1'b0);
        end

        drain();
        if (corner_errors == 0)
            $display("diagonal_corner_finder_core test passed");
        else
            $display("diagonal_corner_finder_core test failed");
        $finish;
    end

endmodule
